@@ rtl/spm_pkg.sv @@
package spm_pkg;

  // Fixed field widths of the request and response items.
  localparam int PRIO_W = 5;
  localparam int TAG_W  = 16;

  // Number of priority levels and the number of tag bits kept in the store.
  localparam int PRIORITY_LEVELS = 32;
  localparam int TAG_BITS        = 16;

  localparam logic [TAG_W-1:0] TAG_MASK =
    (TAG_BITS >= TAG_W) ? {TAG_W{1'b1}} : TAG_W'((64'd1 << TAG_BITS) - 64'd1);

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_POPPED = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // Contents of one cell of the ordered row.
  typedef struct packed {
    logic              valid;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // Command broadcast to every cell in the row.
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } cell_cmd_t;

  // Priorities above the last level fold onto the last level.
  function automatic logic [PRIO_W-1:0] sat_prio(input logic [PRIO_W-1:0] p);
    logic [PRIO_W-1:0] res;
    if (int'(p) < PRIORITY_LEVELS) begin
      res = p;
    end else begin
      res = PRIO_W'(PRIORITY_LEVELS - 1);
    end
    return res;
  endfunction

endpackage

@@ rtl/spm_if.sv @@
interface spm_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [spm_pkg::PRIO_W-1:0] priority_req;
  logic [spm_pkg::TAG_W-1:0]  job_tag;

  modport source (output valid, req_type, priority_req, job_tag, input ready);
  modport sink   (input valid, req_type, priority_req, job_tag, output ready);
endinterface

interface spm_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [spm_pkg::PRIO_W-1:0] out_priority;
  logic [spm_pkg::TAG_W-1:0]  out_tag;

  modport source (output valid, status, out_priority, out_tag, input ready);
  modport sink   (input valid, status, out_priority, out_tag, output ready);
endinterface

@@ rtl/spm_cell.sv @@
module spm_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  spm_pkg::cell_cmd_t cmd,
  input  spm_pkg::entry_t    left_entry,
  input  logic               left_ahead,
  input  spm_pkg::entry_t    right_entry,
  output spm_pkg::entry_t    entry_o,
  output logic               ahead_o
);

  logic                       valid_r;
  logic [spm_pkg::PRIO_W-1:0] prio_r;
  logic [spm_pkg::TAG_W-1:0]  tag_r;
  spm_pkg::entry_t            entry_nxt;

  assign entry_o = '{valid: valid_r, prio: prio_r, tag: tag_r};

  // An entry stays ahead of a new one when its priority is equal or more
  // urgent, which keeps jobs of one level in arrival order.
  assign ahead_o = valid_r && (prio_r <= cmd.prio);

  always_comb begin
    entry_nxt = entry_o;
    if (cmd.pop) begin
      entry_nxt = right_entry;
    end else if (cmd.push && !ahead_o) begin
      if (left_ahead) begin
        entry_nxt = '{valid: 1'b1, prio: cmd.prio, tag: cmd.tag};
      end else begin
        entry_nxt = left_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= entry_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= entry_nxt.prio;
    tag_r  <= entry_nxt.tag;
  end

endmodule

@@ rtl/strict_priority_multi_fifo.sv @@
// Channel   Direction  Handshake     Payload
// in_req    sink       valid/ready   req_type, priority_req, job_tag
// out_rsp   source     valid/ready   status, out_priority, out_tag
//
// Every request produces exactly one response, registered in the cycle after it
// is accepted. A request can be accepted in every cycle while responses are taken;
// the row updates as it is taken, so the response register sets the pace.
// Reset (rst_n low at a clock edge) empties every cell at once; no sweep.
// A stalled response holds in the output register and blocks new requests
// until it is taken; a request is taken in the same cycle its way clears.
module strict_priority_multi_fifo #(
  parameter int ENTRY_COUNT = 64
) (
  input logic       clk,
  input logic       rst_n,
  spm_req_if.sink   in_req,
  spm_rsp_if.source out_rsp
);

  // The queues of all priority levels are kept as one row of cells, ordered
  // by priority and, within a level, by arrival. Cell 0 always holds the job
  // that the next pop returns. A push drops the new job into the first cell
  // whose job is less urgent and moves every later job one cell to the right;
  // a pop moves every job one cell to the left.
  spm_pkg::entry_t    cell_q  [ENTRY_COUNT];
  logic               ahead   [ENTRY_COUNT];
  logic [ENTRY_COUNT-1:0] valid_vec;
  spm_pkg::cell_cmd_t cmd;

  logic accept;
  logic is_push;
  logic full;
  logic empty;

  logic                       out_valid_r;
  spm_pkg::status_t           status_r;
  logic [spm_pkg::PRIO_W-1:0] prio_r;
  logic [spm_pkg::TAG_W-1:0]  tag_r;
  spm_pkg::status_t           status_nxt;
  logic [spm_pkg::PRIO_W-1:0] prio_nxt;
  logic [spm_pkg::TAG_W-1:0]  tag_nxt;

  // The store is full when the last cell is occupied, and empty when the
  // first one is not.
  assign full  = cell_q[ENTRY_COUNT-1].valid;
  assign empty = !cell_q[0].valid;

  assign in_req.ready = !out_valid_r || out_rsp.ready;
  assign accept       = in_req.valid && in_req.ready;
  assign is_push      = (in_req.req_type == spm_pkg::REQ_PUSH);

  // Rejected requests leave the row untouched.
  assign cmd.push = accept && is_push && !full;
  assign cmd.pop  = accept && !is_push && !empty;
  assign cmd.prio = spm_pkg::sat_prio(in_req.priority_req);
  assign cmd.tag  = in_req.job_tag & spm_pkg::TAG_MASK;

  for (genvar i = 0; i < ENTRY_COUNT; i++) begin : g_cell
    spm_pkg::entry_t left_entry;
    spm_pkg::entry_t right_entry;
    logic            left_ahead;

    if (i == 0) begin : g_first
      // Nothing stands to the left of the head cell, so a new job that is
      // not behind it lands there.
      assign left_entry = '0;
      assign left_ahead = 1'b1;
    end else begin : g_inner_left
      assign left_entry = cell_q[i-1];
      assign left_ahead = ahead[i-1];
    end

    if (i == ENTRY_COUNT - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_inner_right
      assign right_entry = cell_q[i+1];
    end

    spm_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .left_entry  (left_entry),
      .left_ahead  (left_ahead),
      .right_entry (right_entry),
      .entry_o     (cell_q[i]),
      .ahead_o     (ahead[i])
    );

    assign valid_vec[i] = cell_q[i].valid;
  end

  // Response for the request taken in this cycle, built from the row as it
  // stands before the update.
  always_comb begin
    prio_nxt = '0;
    tag_nxt  = '0;
    if (is_push) begin
      status_nxt = full ? spm_pkg::ST_FULL : spm_pkg::ST_PUSHED;
    end else if (empty) begin
      status_nxt = spm_pkg::ST_EMPTY;
    end else begin
      status_nxt = spm_pkg::ST_POPPED;
      prio_nxt   = cell_q[0].prio;
      tag_nxt    = cell_q[0].tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      prio_r   <= prio_nxt;
      tag_r    <= tag_nxt;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = status_r;
  assign out_rsp.out_priority = prio_r;
  assign out_rsp.out_tag      = tag_r;

  // Occupied cells always form one unbroken run starting at cell 0.
  a_packed_row: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("occupied cells are not contiguous from the head");

  // A push that is taken grows the row by exactly one job.
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
    else $error("accepted push did not add exactly one job");

  // A pop that is taken shrinks the row by exactly one job.
  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> $countones(valid_vec) + 1 == $past($countones(valid_vec)))
    else $error("accepted pop did not remove exactly one job");

  // A push into a full row is answered as rejected.
  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_push && full |=> out_rsp.valid && out_rsp.status == spm_pkg::ST_FULL)
    else $error("push into a full store was not rejected");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

// Checks the strict-priority scheduler against a linked-list store model that
// is kept inside this testbench.

module testbench;

  // Store depth handed to the block. The model below uses the same depth.
  localparam int STORE_DEPTH  = 64;
  localparam int SLOT_W       = $clog2(STORE_DEPTH);
  localparam int PRIO_W       = spm_pkg::PRIO_W;
  localparam int TAG_W        = spm_pkg::TAG_W;
  localparam int LEVELS       = spm_pkg::PRIORITY_LEVELS;
  // The limit allows for the slowest correct run, with both sides idle at their
  // worst, plus the long hold-off, many times over.
  localparam int CYCLE_LIMIT  = 200000;
  // A response shows in the cycle after its request is taken, so a short tail is enough.
  localparam int SETTLE_TICKS = 8;

  // One response as the scheduler should report it.
  typedef struct packed {
    spm_pkg::status_t  status;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } job_result_t;

  logic clk;
  logic rst_n;

  spm_req_if in_req ();
  spm_rsp_if out_rsp ();

  strict_priority_multi_fifo #(
    .ENTRY_COUNT(STORE_DEPTH)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp)
  );

  // Scheduler model: one linked list per priority level, all of them threaded
  // through a shared store, with unused slots chained on a free list.
  logic [SLOT_W-1:0]          level_head [LEVELS];
  logic [SLOT_W-1:0]          level_tail [LEVELS];
  logic [LEVELS-1:0]          level_busy;
  logic [SLOT_W-1:0]          slot_link  [STORE_DEPTH];
  logic [TAG_W-1:0]           slot_tag   [STORE_DEPTH];
  logic [SLOT_W-1:0]          free_slot;
  int                         slots_used;

  // Responses that the scheduler still owes, oldest first.
  job_result_t owed_results [$];

  // Run bookkeeping.
  int  mismatches;
  int  cycle_count;
  int  requests_sent;
  int  status_seen [4];
  int  deepest_fill;
  bit  sender_gaps;
  bit  receiver_gaps;
  int  receiver_hold;

  // The clock runs free from time zero.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bring the model to its reset state: every slot free and chained in order,
  // no level holding a job.
  function automatic void clear_scheduler_model();
    int i;
    for (i = 0; i < STORE_DEPTH; i++) begin
      slot_link[i] = SLOT_W'((i + 1) % STORE_DEPTH);
      slot_tag[i]  = '0;
    end
    for (i = 0; i < LEVELS; i++) begin
      level_head[i] = '0;
      level_tail[i] = '0;
    end
    level_busy = '0;
    free_slot  = '0;
    slots_used = 0;
  endfunction

  // Work out the response to one accepted request and advance the model.
  function automatic job_result_t schedule_job(input spm_pkg::req_kind_t kind,
                                               input logic [PRIO_W-1:0] prio,
                                               input logic [TAG_W-1:0] tag);
    job_result_t       res;
    logic [PRIO_W-1:0] level;
    logic [SLOT_W-1:0] slot;
    int                urgent;
    int                i;
    res.status = spm_pkg::ST_PUSHED;
    res.prio   = '0;
    res.tag    = '0;
    if (kind == spm_pkg::REQ_PUSH) begin
      if (slots_used >= STORE_DEPTH) begin
        // The store is full: nothing moves and the push is turned away.
        res.status = spm_pkg::ST_FULL;
      end else begin
        // Priorities past the last level fold onto the last level.
        level = (int'(prio) < LEVELS) ? prio : PRIO_W'(LEVELS - 1);
        slot           = free_slot;
        free_slot      = slot_link[slot];
        slot_tag[slot] = tag & spm_pkg::TAG_MASK;
        if (level_busy[level]) begin
          slot_link[level_tail[level]] = slot;
          level_tail[level]            = slot;
        end else begin
          level_head[level] = slot;
          level_tail[level] = slot;
          level_busy[level] = 1'b1;
        end
        slots_used++;
        if (slots_used > deepest_fill) begin
          deepest_fill = slots_used;
        end
      end
    end else begin
      // Lowest-numbered level with a job wins.
      urgent = LEVELS;
      for (i = LEVELS - 1; i >= 0; i--) begin
        if (level_busy[i]) begin
          urgent = i;
        end
      end
      if (urgent == LEVELS) begin
        res.status = spm_pkg::ST_EMPTY;
      end else begin
        slot       = level_head[urgent];
        res.status = spm_pkg::ST_POPPED;
        res.prio   = PRIO_W'(urgent);
        res.tag    = slot_tag[slot];
        // A level whose head is also its tail held a single job.
        if (level_head[urgent] == level_tail[urgent]) begin
          level_busy[urgent] = 1'b0;
        end else begin
          level_head[urgent] = slot_link[slot];
        end
        slot_link[slot] = free_slot;
        free_slot       = slot;
        slots_used--;
      end
    end
    return res;
  endfunction

  // Offer one request, starting just after a falling edge, and return just
  // after the falling edge that follows its acceptance. The model advances at
  // the rising edge where valid and ready are both high.
  task automatic send_request(input spm_pkg::req_kind_t kind,
                              input logic [PRIO_W-1:0] prio,
                              input logic [TAG_W-1:0] tag);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      in_req.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_req.valid        = 1'b1;
    in_req.req_type     = kind;
    in_req.priority_req = prio;
    in_req.job_tag      = tag;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    owed_results.push_back(schedule_job(kind, prio, tag));
    requests_sent++;
    @(negedge clk);
    // A following call in the same time step raises valid again before the
    // block can see the low value, so back-to-back requests stay gapless.
    in_req.valid = 1'b0;
  endtask

  // One random request. Pops carry random priority and tag bits too, since
  // the block must ignore them.
  task automatic send_random_request(input int push_percent, input int top_level);
    spm_pkg::req_kind_t kind;
    kind = ($urandom_range(0, 99) < push_percent) ? spm_pkg::REQ_PUSH : spm_pkg::REQ_POP;
    send_request(kind, PRIO_W'($urandom_range(0, top_level)), TAG_W'($urandom));
  endtask

  // Hand-picked cases: empty pops, the extremes of priority and tag, FIFO
  // order within a level, the order across levels, and a level that holds a
  // single job.
  task automatic test_directed();
    send_request(spm_pkg::REQ_POP,  5'd0,  16'h0000);
    send_request(spm_pkg::REQ_POP,  5'd31, 16'hFFFF);
    send_request(spm_pkg::REQ_PUSH, 5'd31, 16'hFFFF);
    send_request(spm_pkg::REQ_PUSH, 5'd0,  16'h0000);
    send_request(spm_pkg::REQ_PUSH, 5'd0,  16'h5A5A);
    send_request(spm_pkg::REQ_PUSH, 5'd16, 16'h8000);
    send_request(spm_pkg::REQ_PUSH, 5'd1,  16'h0001);
    send_request(spm_pkg::REQ_POP,  5'd31, 16'h1234);
    send_request(spm_pkg::REQ_POP,  5'd0,  16'h0000);
    send_request(spm_pkg::REQ_POP,  5'd0,  16'h0000);
    send_request(spm_pkg::REQ_POP,  5'd0,  16'h0000);
    send_request(spm_pkg::REQ_POP,  5'd0,  16'h0000);
    send_request(spm_pkg::REQ_POP,  5'd0,  16'h0000);
    send_request(spm_pkg::REQ_PUSH, 5'd7,  16'hA5A5);
    send_request(spm_pkg::REQ_PUSH, 5'd7,  16'h7FFF);
    send_request(spm_pkg::REQ_PUSH, 5'd6,  16'h00FF);
    send_request(spm_pkg::REQ_POP,  5'd0,  16'h0000);
    send_request(spm_pkg::REQ_POP,  5'd0,  16'h0000);
    send_request(spm_pkg::REQ_POP,  5'd0,  16'h0000);
    send_request(spm_pkg::REQ_POP,  5'd0,  16'h0000);
  endtask

  // Random traffic in phases of changing push pressure. Push-heavy phases fill
  // the whole store and run into rejected pushes; pop-heavy phases drain it and
  // keep popping on empty. Some phases crowd a few levels so that long FIFO
  // chains build up inside one level.
  task automatic test_random_phases();
    int push_bias [9] = '{50, 92, 90, 10, 55, 95, 5, 70, 30};
    int phase;
    int n;
    int top_level;
    for (phase = 0; phase < 9; phase++) begin
      top_level = (phase % 3 == 1) ? 3 : LEVELS - 1;
      for (n = 0; n < 85; n++) begin
        send_random_request(push_bias[phase], top_level);
      end
    end
  endtask

  // The receiver stops taking responses for a long stretch while requests keep
  // coming, so the response register fills and the input stalls.
  task automatic test_backpressure();
    int n;
    receiver_hold = 300;
    for (n = 0; n < 40; n++) begin
      send_random_request(60, LEVELS - 1);
    end
  endtask

  // Last stretch: both sides at full rate, no idle cycles anywhere.
  task automatic test_full_rate();
    int n;
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    for (n = 0; n < 70; n++) begin
      send_random_request(50, LEVELS - 1);
    end
  endtask

  // Receiver: random stalls, plus the long hold-off that a test can ask for,
  // counted here cycle by cycle.
  initial begin
    out_rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (receiver_hold > 0) begin
        out_rsp.ready = 1'b0;
        repeat (receiver_hold) @(negedge clk);
        receiver_hold = 0;
        out_rsp.ready = 1'b1;
      end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
        out_rsp.ready = 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end else begin
        out_rsp.ready = 1'b1;
      end
    end
  end

  // Compare every response taken with the oldest one the model expects.
  always @(posedge clk) begin
    job_result_t want;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (owed_results.size() == 0) begin
        $error("response arrived with no request outstanding: status %0d",
               out_rsp.status);
        mismatches++;
      end else begin
        want = owed_results.pop_front();
        status_seen[out_rsp.status]++;
        if (out_rsp.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_rsp.status);
          mismatches++;
        end
        if (out_rsp.out_priority !== want.prio) begin
          $error("out_priority: expected %0d, actual %0d", want.prio,
                 out_rsp.out_priority);
          mismatches++;
        end
        if (out_rsp.out_tag !== want.tag) begin
          $error("out_tag: expected 0x%04h, actual 0x%04h", want.tag, out_rsp.out_tag);
          mismatches++;
        end
      end
    end
  end

  // Watchdog. A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d responses owed", cycle_count,
               owed_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    in_req.valid        = 1'b0;
    in_req.req_type     = spm_pkg::REQ_PUSH;
    in_req.priority_req = '0;
    in_req.job_tag      = '0;
    rst_n               = 1'b0;
    mismatches          = 0;
    cycle_count         = 0;
    requests_sent       = 0;
    deepest_fill        = 0;
    status_seen         = '{0, 0, 0, 0};
    sender_gaps         = 1'b1;
    receiver_gaps       = 1'b1;
    receiver_hold       = 0;
    clear_scheduler_model();

    // Synchronous reset, held low while the clock runs and released on a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_random_phases();
    test_backpressure();
    test_full_rate();

    // Let every owed response come out, then wait out a short settling tail so
    // the block can show anything it should not send. The watchdog bounds this wait.
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);

    $display("Sent %0d requests: %0d pushed, %0d popped, %0d pushes rejected as full,",
             requests_sent, status_seen[spm_pkg::ST_PUSHED],
             status_seen[spm_pkg::ST_POPPED], status_seen[spm_pkg::ST_FULL]);
    $display("%0d pops on an empty scheduler; the store peaked at %0d of %0d slots.",
             status_seen[spm_pkg::ST_EMPTY], deepest_fill, STORE_DEPTH);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/spm_pkg.sv
rtl/spm_if.sv
rtl/spm_cell.sv
rtl/strict_priority_multi_fifo.sv
tb/sv/testbench.sv
